>>> rtl/core/gdfp_pkg.sv
// shared types and constants for the grid distance field peak block
// no dependencies; imported by every module of the block
`default_nettype none

package gdfp_pkg;

  localparam int GRID_DIM_DEF   = 32;
  localparam int HEIGHT_CAP_DEF = 255;

  // cell kinds
  localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
  localparam logic [1:0] KIND_DISCOVERED = 2'd1;
  localparam logic [1:0] KIND_OBSTACLE   = 2'd2;

  // request types
  localparam logic REQ_MARK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // register index bit (byte address bit 2)
  localparam logic REG_MARK_AS_OBSTACLE = 1'b0;

  // sub-steps of one cell visit
  localparam logic [2:0] SUB_SELF = 3'd0;
  localparam logic [2:0] SUB_N1   = 3'd1;
  localparam logic [2:0] SUB_N2   = 3'd2;
  localparam logic [2:0] SUB_N3   = 3'd3;
  localparam logic [2:0] SUB_N4   = 3'd4;
  localparam logic [2:0] SUB_WB   = 3'd5;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       mark;
    logic       sweep;
    logic       backward;
    logic       use_req;
    logic       peak_clr;
    logic       res_load;
    logic [2:0] sub;
  } cmd_t;

  typedef struct packed {
    logic req_mark;
    logic in_grid;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/grid_distance_field_peak_core.sv
// top level of the grid distance field peak block: register port, controller, datapath
// depends on gdfp_pkg, gdfp_ctrl and gdfp_datapath
`default_nettype none

// Keeps a GRID_DIM x GRID_DIM map of cell kinds and heights. A mark item
// (req_type 0) sets the addressed cell to discovered, or to obstacle when
// mark_as_obstacle is set, then rebuilds every height as min(HEIGHT_CAP,
// 5 x chessboard distance to the nearest marked cell) and finds the first
// highest cell in column-major order. A read item (req_type 1) changes
// nothing. Each item gives one result: the addressed cell's kind and height
// (both 0 for a cell off the grid, where a mark is ignored) and the peak.
// The rebuild is a forward and a backward raster sweep over a distance
// memory with one read and one write a cycle; each cell takes one self
// read, four neighbour reads and one write. A mark item passes through
// the decide, mark, forward, backward, read and done states, a read item
// or an ignored mark through decide, read and done; the result is loaded
// in done once the result register is free. The next item is taken in
// the cycle after the result is loaded. One item is in work at a time; the
// result register lets the next item in while a result waits. After reset
// a clearing pass over every cell runs before the first item is taken.

module grid_distance_field_peak_core
  import gdfp_pkg::*;
#(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int HEIGHT_CAP = HEIGHT_CAP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [4:0]  cell_x,
  input  wire logic [4:0]  cell_y,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       cell_kind,
  output logic [7:0]       cell_height,
  output logic [4:0]       peak_x,
  output logic [4:0]       peak_y,
  output logic [7:0]       peak_height
);

  localparam int CW = $clog2(GRID_DIM);

  logic          mark_as_obstacle;
  cmd_t          cmd;
  status_t       status;
  logic [CW-1:0] cx, cy;

  // single register, byte address 0; pready tied high
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_as_obstacle <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_MARK_AS_OBSTACLE) begin
      mark_as_obstacle <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_MARK_AS_OBSTACLE) ? {31'd0, mark_as_obstacle} : 32'd0;

  // sequencer
  gdfp_ctrl #(
    .GRID_DIM (GRID_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .cx       (cx),
    .cy       (cy)
  );

  // memories, sweep arithmetic and result register
  gdfp_datapath #(
    .GRID_DIM   (GRID_DIM),
    .HEIGHT_CAP (HEIGHT_CAP)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cx               (cx),
    .cy               (cy),
    .mark_as_obstacle (mark_as_obstacle),
    .req_type         (req_type),
    .cell_x           (cell_x),
    .cell_y           (cell_y),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .cell_kind        (cell_kind),
    .cell_height      (cell_height),
    .peak_x           (peak_x),
    .peak_y           (peak_y),
    .peak_height      (peak_height),
    .status           (status)
  );

endmodule

`default_nettype wire

>>> rtl/core/gdfp_datapath.sv
// datapath: kind, height and distance memories, sweep arithmetic, peak and result registers
// depends on gdfp_pkg
`default_nettype none

module gdfp_datapath
  import gdfp_pkg::*;
#(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int HEIGHT_CAP = HEIGHT_CAP_DEF,
  localparam int CW        = $clog2(GRID_DIM)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          cmd,
  input  wire logic [CW-1:0] cx,
  input  wire logic [CW-1:0] cy,
  input  wire logic          mark_as_obstacle,
  input  wire logic          req_type,
  input  wire logic [4:0]    cell_x,
  input  wire logic [4:0]    cell_y,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [1:0]         cell_kind,
  output logic [7:0]         cell_height,
  output logic [4:0]         peak_x,
  output logic [4:0]         peak_y,
  output logic [7:0]         peak_height,
  output status_t            status
);

  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = CW + 1;
  localparam int HW    = $clog2(HEIGHT_CAP + 1);
  localparam int PW    = DW + 3;
  localparam logic [DW-1:0] FAR  = {DW{1'b1}};
  localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);

  logic [1:0]    kind_mem   [DEPTH];
  logic [HW-1:0] height_mem [DEPTH];
  logic [DW-1:0] dist_mem   [DEPTH];

  logic          req_type_q;
  logic [4:0]    req_x;
  logic [4:0]    req_y;
  logic          in_grid;
  logic [CW-1:0] ax, ay, nx, ny;
  logic          x_inc, x_dec, y_inc, y_dec, nb_ok;
  logic [AW-1:0] raddr, waddr;

  logic [1:0]    kind_rd;
  logic [HW-1:0] height_rd;
  logic [DW-1:0] dist_rd;
  logic          nb_ok_q;

  logic [DW-1:0] acc;
  logic [DW-1:0] acc_next;
  logic [DW:0]   cand;
  logic [PW-1:0] prod;
  logic [HW-1:0] hval;

  logic [CW-1:0] pk_x, pk_y;
  logic [HW-1:0] pk_h;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= req_type;
      req_x      <= cell_x;
      req_y      <= cell_y;
    end
  end

  assign in_grid = (32'(req_x) < 32'(GRID_DIM)) && (32'(req_y) < 32'(GRID_DIM));
  assign ax      = cmd.use_req ? CW'(req_x) : cx;
  assign ay      = cmd.use_req ? CW'(req_y) : cy;

  // neighbour offsets; the backward pass mirrors the forward one
  always_comb begin
    x_inc = 1'b0;
    x_dec = 1'b0;
    y_inc = 1'b0;
    y_dec = 1'b0;
    if (cmd.sweep) begin
      unique case (cmd.sub)
        SUB_N1: begin
          x_dec = 1'b1;
        end
        SUB_N2: begin
          x_dec = 1'b1;
          y_dec = 1'b1;
        end
        SUB_N3: begin
          y_dec = 1'b1;
        end
        SUB_N4: begin
          x_inc = 1'b1;
          y_dec = 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd.backward) begin
        {x_inc, x_dec} = {x_dec, x_inc};
        {y_inc, y_dec} = {y_dec, y_inc};
      end
    end
  end

  assign nx    = x_inc ? ax + 1'b1 : (x_dec ? ax - 1'b1 : ax);
  assign ny    = y_inc ? ay + 1'b1 : (y_dec ? ay - 1'b1 : ay);
  assign nb_ok = !(x_inc && ax == LAST) && !(x_dec && ax == '0) &&
                 !(y_inc && ay == LAST) && !(y_dec && ay == '0);
  assign raddr = {nx, ny};
  assign waddr = {ax, ay};

  always_ff @(posedge clk) begin
    kind_rd   <= kind_mem[raddr];
    height_rd <= height_mem[raddr];
    dist_rd   <= dist_mem[raddr];
    nb_ok_q   <= nb_ok;
  end

  // running minimum over the cell and its already visited neighbours
  assign cand = {1'b0, dist_rd} + 1'b1;
  always_comb begin
    acc_next = acc;
    if (cmd.sub == SUB_N1) begin
      if (cmd.backward) begin
        acc_next = dist_rd;
      end else begin
        acc_next = (kind_rd != KIND_UNKNOWN) ? '0 : FAR;
      end
    end else if (nb_ok_q && cand < {1'b0, acc}) begin
      acc_next = DW'(cand);
    end
  end

  assign prod = PW'({acc_next, 2'b00}) + PW'(acc_next);
  assign hval = (32'(prod) > 32'(HEIGHT_CAP)) ? HW'(HEIGHT_CAP) : HW'(prod);

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      kind_mem[waddr] <= KIND_UNKNOWN;
    end else if (cmd.mark) begin
      kind_mem[waddr] <= mark_as_obstacle ? KIND_OBSTACLE : KIND_DISCOVERED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      height_mem[waddr] <= '0;
    end else if (cmd.sweep && cmd.backward && cmd.sub == SUB_WB) begin
      height_mem[waddr] <= hval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep && cmd.sub == SUB_WB) begin
      dist_mem[waddr] <= acc_next;
    end
  end

  // first greatest in x-major order: ties go to the smaller cell index
  always_ff @(posedge clk) begin
    if (rst || cmd.peak_clr) begin
      pk_x <= '0;
      pk_y <= '0;
      pk_h <= '0;
    end else if (cmd.sweep && cmd.backward && cmd.sub == SUB_WB) begin
      if (hval > pk_h || (hval == pk_h && {ax, ay} < {pk_x, pk_y})) begin
        pk_x <= ax;
        pk_y <= ay;
        pk_h <= hval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cell_kind   <= in_grid ? kind_rd : KIND_UNKNOWN;
      cell_height <= in_grid ? 8'(height_rd) : 8'd0;
      peak_x      <= 5'(pk_x);
      peak_y      <= 5'(pk_y);
      peak_height <= 8'(pk_h);
    end
  end

  assign status.req_mark = (req_type_q == REQ_MARK);
  assign status.in_grid  = in_grid;
  assign status.out_full = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> rtl/core/gdfp_ctrl.sv
// controller: clearing pass, mark, forward and backward sweeps, result capture
// depends on gdfp_pkg
`default_nettype none

module gdfp_ctrl
  import gdfp_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  localparam int CW      = $clog2(GRID_DIM)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire status_t       status,
  output cmd_t               cmd,
  output logic [CW-1:0]      cx,
  output logic [CW-1:0]      cy
);

  localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_MARK, S_FWD, S_BWD, S_READ, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] sub;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.sub      = SUB_SELF;
    cmd.load     = in_valid && in_ready;
    unique case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_MARK: begin
        cmd.mark     = 1'b1;
        cmd.use_req  = 1'b1;
        cmd.peak_clr = 1'b1;
      end
      S_FWD: begin
        cmd.sweep = 1'b1;
        cmd.sub   = sub;
      end
      S_BWD: begin
        cmd.sweep    = 1'b1;
        cmd.backward = 1'b1;
        cmd.sub      = sub;
      end
      S_READ: cmd.use_req = 1'b1;
      S_DONE: begin
        cmd.use_req  = 1'b1;
        cmd.res_load = !status.out_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cx    <= '0;
      cy    <= '0;
      sub   <= SUB_SELF;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cy == LAST) begin
            cy <= '0;
            if (cx == LAST) begin
              cx    <= '0;
              state <= S_IDLE;
            end else begin
              cx <= cx + 1'b1;
            end
          end else begin
            cy <= cy + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= (status.req_mark && status.in_grid) ? S_MARK : S_READ;
        end
        S_MARK: begin
          cx    <= '0;
          cy    <= '0;
          sub   <= SUB_SELF;
          state <= S_FWD;
        end
        S_FWD: begin
          if (sub == SUB_WB) begin
            sub <= SUB_SELF;
            if (cx == LAST) begin
              cx <= '0;
              if (cy == LAST) begin
                cx    <= LAST;
                state <= S_BWD;
              end else begin
                cy <= cy + 1'b1;
              end
            end else begin
              cx <= cx + 1'b1;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_BWD: begin
          if (sub == SUB_WB) begin
            sub <= SUB_SELF;
            if (cx == '0) begin
              cx <= LAST;
              if (cy == '0) begin
                cx    <= '0;
                state <= S_READ;
              end else begin
                cy <= cy - 1'b1;
              end
            end else begin
              cx <= cx - 1'b1;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (!status.out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
